// ----- design/hsrt_pkg.sv -----
// Package for the humidity sensor read tracker.
// Holds request codes, pending-kind codes, frame byte positions, conversion wait tables and the CRC-8 step.
// No dependencies.
package hsrt_pkg;

   // request codes carried in req_tuser
   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_TEMP = 2'd1,
      REQ_HUM  = 2'd2,
      REQ_BYTE = 2'd3
   } req_kind_type;

   // pending measurement kind
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TEMP = 2'd1;
   localparam logic [1:0] KIND_HUM  = 2'd2;

   // frame byte position
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;

   localparam int          ElapsedW   = 7;
   localparam logic [6:0]  ElapsedMax = 7'd127;
   localparam logic [7:0]  CrcPoly    = 8'h31;
   localparam logic [15:0] RawMask    = 16'hFFFC;
   localparam logic [7:0]  StatusMask = 8'h03;

   // conversion wait in ms for a kind and resolution code
   function automatic logic [ElapsedW-1:0] wait_ms(input logic [1:0] kind,
                                                    input logic [1:0] res);
      logic [ElapsedW-1:0] t;
      t = '0;
      if (kind == KIND_TEMP) begin
         case (res)
            2'd0:    t = 7'd85;
            2'd1:    t = 7'd22;
            2'd2:    t = 7'd43;
            default: t = 7'd11;
         endcase
      end else begin
         case (res)
            2'd0:    t = 7'd29;
            2'd1:    t = 7'd4;
            2'd2:    t = 7'd9;
            default: t = 7'd15;
         endcase
      end
      return t;
   endfunction

   // one byte through CRC-8, MSB first, eight shift steps
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ CrcPoly;
         else      c = {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ----- design/humidity_sensor_read_tracker_top.sv -----
// Top level of the humidity sensor read tracker.
// Depends on hsrt_pkg (codes, wait tables, CRC-8 step).
//
//   channel  | direction | tdata                         | tuser
//   ---------+-----------+-------------------------------+------------------------
//   req      | in        | data_byte[7:0]                | req_type[1:0]
//   rsp      | out       | ready_res, pending_kind,      | frame_done, frame_kind
//            |           | raw_value, status_bits, crc   |
//   csr      | in        | resolution[1:0] on csr_wen    | -
//
// One item per cycle while rsp is not stalled; the result is registered and appears in the cycle after the transfer in.
// The rsp output register parts the two sides: req_tready stays high while that
// register is empty or being drained in the same cycle.
// The CRC of the first byte is taken when it arrives, so the third byte sees one
// CRC-8 step plus the compare.
// reset is synchronous, active high, and clears tracker state and rsp_tvalid.
module humidity_sensor_read_tracker_top (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic [1:0]  csr_wdata,   // resolution
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] ready_res, [2:1] pending_kind, [18:3] raw_value,
                                    // [20:19] status_bits, [21] crc_error, [23:22] zero
   output logic [2:0]  rsp_tuser    // [0] frame_done, [2:1] frame_kind
);

   logic [1:0] resolution_ff;
   logic [1:0] pending_ff,  pending_in;
   logic [6:0] elapsed_ff,  elapsed_in;
   logic [1:0] count_ff,    count_in;
   logic [7:0] first_ff,    first_in;
   logic [7:0] second_ff,   second_in;
   logic [7:0] crc1_ff,     crc1_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff,  rsp_data_in;
   logic [2:0]  rsp_user_ff,  rsp_user_in;

   logic        accept;
   logic        done;
   logic [1:0]  fkind;
   logic [15:0] raw;
   logic [1:0]  status;
   logic        crc_err;
   logic        ready;
   logic [7:0]  crc_full;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // resolution register
   always_ff @(posedge clock) begin
      if (reset)        resolution_ff <= 2'd0;
      else if (csr_wen) resolution_ff <= csr_wdata;
   end

   // next tracker state and result fields
   always_comb begin
      pending_in = pending_ff;
      elapsed_in = elapsed_ff;
      count_in   = count_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      crc1_in    = crc1_ff;
      done       = 1'b0;
      fkind      = hsrt_pkg::KIND_NONE;
      raw        = '0;
      status     = '0;
      crc_err    = 1'b0;
      crc_full   = hsrt_pkg::crc8_step(crc1_ff, second_ff);
      case (hsrt_pkg::req_kind_type'(req_tuser))
         hsrt_pkg::REQ_TICK: begin
            if (elapsed_ff != hsrt_pkg::ElapsedMax) elapsed_in = elapsed_ff + 7'd1;
         end
         hsrt_pkg::REQ_TEMP, hsrt_pkg::REQ_HUM: begin
            pending_in = req_tuser;
            elapsed_in = '0;
            count_in   = hsrt_pkg::POS_FIRST;
         end
         hsrt_pkg::REQ_BYTE: begin
            case (count_ff)
               hsrt_pkg::POS_FIRST: begin
                  first_in = req_tdata;
                  crc1_in  = hsrt_pkg::crc8_step(8'h00, req_tdata);
                  count_in = hsrt_pkg::POS_SECOND;
               end
               hsrt_pkg::POS_SECOND: begin
                  second_in = req_tdata;
                  count_in  = hsrt_pkg::POS_THIRD;
               end
               default: begin
                  done       = 1'b1;
                  fkind      = pending_ff;
                  raw        = {first_ff, second_ff} & hsrt_pkg::RawMask;
                  status     = 2'(second_ff & hsrt_pkg::StatusMask);
                  crc_err    = (crc_full != req_tdata);
                  pending_in = hsrt_pkg::KIND_NONE;
                  count_in   = hsrt_pkg::POS_FIRST;
               end
            endcase
         end
         default: ;
      endcase
      // ready against the state after this item
      ready = ((pending_in == hsrt_pkg::KIND_TEMP) || (pending_in == hsrt_pkg::KIND_HUM))
              && (elapsed_in >= hsrt_pkg::wait_ms(pending_in, resolution_ff));
      rsp_data_in = {2'b00, crc_err, status, raw, pending_in, ready};
      rsp_user_in = {fkind, done};
   end

   // tracker state, updated on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= hsrt_pkg::KIND_NONE;
         elapsed_ff <= '0;
         count_ff   <= hsrt_pkg::POS_FIRST;
         first_ff   <= '0;
         second_ff  <= '0;
         crc1_ff    <= '0;
      end else if (accept) begin
         pending_ff <= pending_in;
         elapsed_ff <= elapsed_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         crc1_ff    <= crc1_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // frame position never reaches the unused code
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("frame byte count out of range");

   // a finished frame always leaves nothing pending
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff[0]) |-> (rsp_data_ff[2:1] == hsrt_pkg::KIND_NONE))
      else $error("pending kind not cleared after frame");

   // frame fields are zero unless the frame completed
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff[0]) |->
         (rsp_data_ff[21:3] == '0 && rsp_user_ff[2:1] == hsrt_pkg::KIND_NONE))
      else $error("frame fields set without a completed frame");

   // saturated counter holds unless a request restarts it
   a_elapsed_sat: assert property (@(posedge clock) disable iff (reset)
      (elapsed_ff == hsrt_pkg::ElapsedMax && !(accept &&
         (req_tuser == hsrt_pkg::REQ_TEMP || req_tuser == hsrt_pkg::REQ_HUM)))
      |=> (elapsed_ff == hsrt_pkg::ElapsedMax))
      else $error("elapsed counter left saturation");

   // ready only with a measurement pending
   a_ready_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> (rsp_data_ff[2:1] != hsrt_pkg::KIND_NONE))
      else $error("ready raised with nothing pending");

endmodule
